// ----- rtl/core/mbslv_pkg.sv -----
package mbslv_pkg;

    // Item kinds carried on the input tuser
    localparam logic [2:0] REQ_PDU       = 3'd0;
    localparam logic [2:0] REQ_LOAD_DISC = 3'd1;
    localparam logic [2:0] REQ_LOAD_INW  = 3'd2;
    localparam logic [2:0] REQ_LOAD_COIL = 3'd3;
    localparam logic [2:0] REQ_LOAD_HOLD = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_UNIT     = 3'd0;
    localparam logic [2:0] CFG_COIL     = 3'd1;
    localparam logic [2:0] CFG_DISCRETE = 3'd2;
    localparam logic [2:0] CFG_HOLDING  = 3'd3;
    localparam logic [2:0] CFG_INPUT    = 3'd4;

    // Function codes
    localparam logic [7:0] FC_RD_COILS    = 8'h01;
    localparam logic [7:0] FC_RD_DISCRETE = 8'h02;
    localparam logic [7:0] FC_RD_HOLDING  = 8'h03;
    localparam logic [7:0] FC_RD_INPUT    = 8'h04;
    localparam logic [7:0] FC_WR_COIL     = 8'h05;
    localparam logic [7:0] FC_WR_REG      = 8'h06;
    localparam logic [7:0] FC_WR_COILS    = 8'h0F;
    localparam logic [7:0] FC_WR_REGS     = 8'h10;
    localparam logic [7:0] FC_EXC_FLAG    = 8'h80;

    // Exception codes (zero means no exception)
    localparam logic [1:0] EXC_NONE     = 2'd0;
    localparam logic [1:0] EXC_FUNCTION = 2'd1;
    localparam logic [1:0] EXC_ADDRESS  = 2'd2;
    localparam logic [1:0] EXC_VALUE    = 2'd3;

    localparam logic [15:0] COIL_ON       = 16'hFF00;
    localparam logic [15:0] MAX_RD_BITS   = 16'd2000;
    localparam logic [15:0] MAX_RD_WORDS  = 16'd125;
    localparam logic [15:0] MAX_WR_BITS   = 16'd1968;
    localparam logic [15:0] MAX_WR_WORDS  = 16'd123;

    localparam int LEN_W   = 10;   // request length, up to 1023 bytes
    localparam int QUEUE_D = 4;

    typedef struct packed {
        logic [2:0]       kind;
        logic [9:0]       load_index;
        logic [15:0]      load_value;
        logic [7:0]       unit;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  unit_address;
        logic [15:0] coil_base;
        logic [15:0] discrete_base;
        logic [15:0] holding_base;
        logic [15:0] input_word_base;
    } cfg_t;

    typedef struct packed {
        logic       start;
        logic [8:0] total;
        logic       exc;
        logic       valid;
        logic [7:0] data;
    } emit_t;

endpackage

// ----- rtl/core/mbslv_front.sv -----
module mbslv_front
    import mbslv_pkg::*;
#(
    parameter int PDU_BYTES = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [47:0]                  s_tdata,
    input  logic [2:0]                   s_tuser,
    input  logic                         s_tlast,
    input  logic                         q_full,
    output logic                         q_push,
    output cmd_t                         q_cmd,
    input  logic                         clear_busy,
    input  logic                         exec_done,
    input  logic [$clog2(PDU_BYTES)-1:0] buf_raddr,
    output logic [7:0]                   buf_rdata
);
    localparam int BW = $clog2(PDU_BYTES);
    localparam int LW = $clog2(PDU_BYTES + 1);

    logic [7:0]    buf_mem [PDU_BYTES];
    logic [7:0]    rdata_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] len_after;
    logic          busy_reg;
    logic          busy_next;
    logic          accept;
    logic          room;

    assign s_tready  = !clear_busy && !q_full && !(s_tuser == REQ_PDU && busy_reg);
    assign accept    = s_tvalid && s_tready;
    assign room      = len_reg < LW'(PDU_BYTES);
    assign len_after = room ? len_reg + LW'(1) : len_reg;
    assign buf_rdata = rdata_reg;

    always_comb
    begin
        q_push          = 1'b0;
        q_cmd.kind      = s_tuser;
        q_cmd.load_index = s_tdata[25:16];
        q_cmd.load_value = s_tdata[41:26];
        q_cmd.unit      = s_tdata[15:8];
        q_cmd.len       = LEN_W'(len_after);
        len_next        = len_reg;
        busy_next       = busy_reg;
        if (exec_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            case (s_tuser)
                REQ_PDU:
                begin
                    if (s_tlast)
                    begin
                        q_push    = 1'b1;
                        len_next  = '0;
                        busy_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_after;
                    end
                end
                REQ_LOAD_DISC, REQ_LOAD_INW, REQ_LOAD_COIL, REQ_LOAD_HOLD:
                begin
                    q_push = 1'b1;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == REQ_PDU && room)
        begin
            buf_mem[len_reg[BW-1:0]] <= s_tdata[7:0];
        end
        rdata_reg <= buf_mem[buf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ----- rtl/core/mbslv_queue.sv -----
module mbslv_queue
    import mbslv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);
    localparam int PW = $clog2(QUEUE_D);

    cmd_t          slot_reg [QUEUE_D];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [PW:0]   cnt_reg;

    assign empty = cnt_reg == '0;
    assign full  = cnt_reg == (PW+1)'(QUEUE_D);
    assign head  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (PW+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/core/mbslv_packer.sv -----
module mbslv_packer
    import mbslv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  emit_t       emit,
    output logic        can_emit,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);
    logic [63:0] chunk_reg;
    logic [63:0] chunk_next;
    logic [3:0]  cnt_reg;
    logic [8:0]  rem_reg;
    logic        exc_reg;
    logic        ov_reg;
    logic [63:0] od_reg;
    logic [3:0]  on_reg;
    logic        ol_reg;
    logic        oe_reg;
    logic        push;
    logic        is_last;

    assign can_emit = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, on_reg, od_reg};
    assign m_tuser  = oe_reg;
    assign m_tlast  = ol_reg;
    assign is_last  = rem_reg == 9'd1;
    assign push     = emit.valid && (is_last || cnt_reg == 4'd7);

    always_comb
    begin
        chunk_next = chunk_reg;
        for (int k = 0; k < 8; k++)
        begin
            if (cnt_reg == 4'(k))
            begin
                chunk_next[63-8*k -: 8] = emit.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            od_reg <= chunk_next;
            on_reg <= cnt_reg + 4'd1;
            ol_reg <= is_last;
            oe_reg <= exc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            exc_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (emit.start)
            begin
                chunk_reg <= '0;
                cnt_reg   <= '0;
                rem_reg   <= emit.total;
                exc_reg   <= emit.exc;
            end
            else if (emit.valid)
            begin
                rem_reg <= rem_reg - 9'd1;
                if (push)
                begin
                    chunk_reg <= '0;
                    cnt_reg   <= '0;
                end
                else
                begin
                    chunk_reg <= chunk_next;
                    cnt_reg   <= cnt_reg + 4'd1;
                end
            end
            if (push)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/mbslv_back.sv -----
module mbslv_back
    import mbslv_pkg::*;
#(
    parameter int COIL_DEPTH       = 1024,
    parameter int DISCRETE_DEPTH   = 1024,
    parameter int HOLDING_DEPTH    = 256,
    parameter int INPUT_WORD_DEPTH = 256,
    parameter int PDU_BYTES        = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  cmd_t                         cmd,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic [$clog2(PDU_BYTES)-1:0] buf_raddr,
    input  logic [7:0]                   buf_rdata,
    output emit_t                        emit,
    input  logic                         can_emit,
    output logic                         exec_done,
    output logic                         clear_busy
);
    localparam int BW = $clog2(PDU_BYTES);
    localparam int CI = (COIL_DEPTH > 1) ? $clog2(COIL_DEPTH) : 1;
    localparam int DI = (DISCRETE_DEPTH > 1) ? $clog2(DISCRETE_DEPTH) : 1;
    localparam int HI = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
    localparam int WI = (INPUT_WORD_DEPTH > 1) ? $clog2(INPUT_WORD_DEPTH) : 1;
    localparam int MAXD_A = (COIL_DEPTH > DISCRETE_DEPTH) ? COIL_DEPTH : DISCRETE_DEPTH;
    localparam int MAXD_B = (HOLDING_DEPTH > INPUT_WORD_DEPTH) ? HOLDING_DEPTH
                                                                : INPUT_WORD_DEPTH;
    localparam int MAXD   = (MAXD_A > MAXD_B) ? MAXD_A : MAXD_B;
    localparam logic [16:0] COIL_D17 = 17'(COIL_DEPTH);
    localparam logic [16:0] DISC_D17 = 17'(DISCRETE_DEPTH);
    localparam logic [16:0] HOLD_D17 = 17'(HOLDING_DEPTH);
    localparam logic [16:0] INW_D17  = 17'(INPUT_WORD_DEPTH);
    localparam logic [16:0] MAXD_17  = 17'(MAXD);

    localparam logic [4:0] ST_CLEAR    = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_HDR      = 5'd2;
    localparam logic [4:0] ST_CHK      = 5'd3;
    localparam logic [4:0] ST_START    = 5'd4;
    localparam logic [4:0] ST_PRE      = 5'd5;
    localparam logic [4:0] ST_BIT_REQ  = 5'd6;
    localparam logic [4:0] ST_BIT_GET  = 5'd7;
    localparam logic [4:0] ST_BIT_EMIT = 5'd8;
    localparam logic [4:0] ST_WORD_REQ = 5'd9;
    localparam logic [4:0] ST_WORD_HI  = 5'd10;
    localparam logic [4:0] ST_WORD_LO  = 5'd11;
    localparam logic [4:0] ST_WR5      = 5'd12;
    localparam logic [4:0] ST_WR6      = 5'd13;
    localparam logic [4:0] ST_WC_REQ   = 5'd14;
    localparam logic [4:0] ST_WC_GET   = 5'd15;
    localparam logic [4:0] ST_WC_BIT   = 5'd16;
    localparam logic [4:0] ST_WH_A     = 5'd17;
    localparam logic [4:0] ST_WH_B     = 5'd18;
    localparam logic [4:0] ST_WH_C     = 5'd19;
    localparam logic [4:0] ST_DONE     = 5'd20;

    // stores
    logic        coil_mem [COIL_DEPTH];
    logic        disc_mem [DISCRETE_DEPTH];
    logic [15:0] hold_mem [HOLDING_DEPTH];
    logic [15:0] inw_mem  [INPUT_WORD_DEPTH];
    logic        coil_rd_reg;
    logic        disc_rd_reg;
    logic [15:0] hold_rd_reg;
    logic [15:0] inw_rd_reg;

    logic          coil_we, disc_we, hold_we, inw_we;
    logic [CI-1:0] coil_wa;
    logic [DI-1:0] disc_wa;
    logic [HI-1:0] hold_wa;
    logic [WI-1:0] inw_wa;
    logic          coil_wd, disc_wd;
    logic [15:0]   hold_wd, inw_wd;
    logic          coil_re, disc_re, hold_re, inw_re;

    logic [4:0]       st_reg, st_next;
    logic [47:0]      hdr_reg, hdr_next;
    logic [2:0]       k_reg, k_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       unit_reg, unit_next;
    logic [1:0]       exc_reg, exc_next;
    logic [15:0]      off_reg, off_next;
    logic [10:0]      i_reg, i_next;
    logic [7:0]       acc_reg, acc_next;
    logic [7:0]       hi_reg, hi_next;
    logic [2:0]       e_reg, e_next;
    logic [2:0]       pre_n_reg, pre_n_next;
    logic [4:0]       pre_to_reg, pre_to_next;
    logic [16:0]      clr_reg, clr_next;

    logic [7:0]  fc;
    logic [15:0] a_w;
    logic [15:0] q_w;
    logic [7:0]  bc;
    logic [16:0] q17;
    logic [16:0] bytes_q;
    logic [16:0] el_addr;
    logic [16:0] ld_idx;
    logic        i_end;
    logic [7:0]  pre_byte;
    logic [8:0]  total;
    logic        rd_bit;
    logic [15:0] rd_word;
    logic [11:0] buf_a;

    // request checks
    logic        len5, len_wr_ok, bad3, fits, known;
    logic [15:0] base_sel;
    logic [16:0] depth_sel;
    logic [16:0] qty_sel;
    logic [17:0] span;

    assign fc      = hdr_reg[47:40];
    assign a_w     = hdr_reg[39:24];
    assign q_w     = hdr_reg[23:8];
    assign bc      = hdr_reg[7:0];
    assign q17     = {1'b0, q_w};
    assign bytes_q = (q17 + 17'd7) >> 3;
    assign el_addr = {1'b0, off_reg} + {6'b0, i_reg};
    assign ld_idx  = {7'b0, cmd.load_index};
    assign i_end   = ({5'b0, i_reg} + 16'd1) == q_w;
    assign rd_bit  = (fc == FC_RD_COILS) ? coil_rd_reg : disc_rd_reg;
    assign rd_word = (fc == FC_RD_HOLDING) ? hold_rd_reg : inw_rd_reg;
    assign clear_busy = st_reg == ST_CLEAR;

    always_comb
    begin
        len5      = len_reg == LEN_W'(5);
        len_wr_ok = len_reg == (LEN_W'(6) + LEN_W'(bc));
        known     = 1'b1;
        bad3      = 1'b0;
        base_sel  = cfg.coil_base;
        depth_sel = COIL_D17;
        qty_sel   = q17;
        case (fc)
            FC_RD_COILS, FC_RD_DISCRETE:
            begin
                bad3 = !len5 || q_w == 16'd0 || q_w > MAX_RD_BITS;
                if (fc == FC_RD_DISCRETE)
                begin
                    base_sel  = cfg.discrete_base;
                    depth_sel = DISC_D17;
                end
            end
            FC_RD_HOLDING, FC_RD_INPUT:
            begin
                bad3 = !len5 || q_w == 16'd0 || q_w > MAX_RD_WORDS;
                if (fc == FC_RD_HOLDING)
                begin
                    base_sel  = cfg.holding_base;
                    depth_sel = HOLD_D17;
                end
                else
                begin
                    base_sel  = cfg.input_word_base;
                    depth_sel = INW_D17;
                end
            end
            FC_WR_COIL:
            begin
                bad3    = !len5 || (q_w != COIL_ON && q_w != 16'd0);
                qty_sel = 17'd1;
            end
            FC_WR_REG:
            begin
                bad3      = !len5;
                base_sel  = cfg.holding_base;
                depth_sel = HOLD_D17;
                qty_sel   = 17'd1;
            end
            FC_WR_COILS:
            begin
                bad3 = len_reg < LEN_W'(6) || q_w == 16'd0 || q_w > MAX_WR_BITS
                       || {9'b0, bc} != bytes_q || !len_wr_ok;
            end
            FC_WR_REGS:
            begin
                bad3 = len_reg < LEN_W'(6) || q_w == 16'd0 || q_w > MAX_WR_WORDS
                       || {9'b0, bc} != (q17 << 1) || !len_wr_ok;
                base_sel  = cfg.holding_base;
                depth_sel = HOLD_D17;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
        span = {2'b0, a_w - base_sel} + {1'b0, qty_sel};
        fits = a_w >= base_sel && span <= {1'b0, depth_sel};
    end

    always_comb
    begin
        case (e_reg)
            3'd0:    pre_byte = (exc_reg != EXC_NONE) ? (fc | FC_EXC_FLAG) : fc;
            3'd1:
            begin
                if (exc_reg != EXC_NONE)
                    pre_byte = {6'b0, exc_reg};
                else if (fc == FC_RD_COILS || fc == FC_RD_DISCRETE)
                    pre_byte = bytes_q[7:0];
                else if (fc == FC_RD_HOLDING || fc == FC_RD_INPUT)
                    pre_byte = {q_w[6:0], 1'b0};
                else
                    pre_byte = a_w[15:8];
            end
            3'd2:    pre_byte = a_w[7:0];
            3'd3:    pre_byte = q_w[15:8];
            default: pre_byte = q_w[7:0];
        endcase
        if (exc_reg != EXC_NONE)
            total = 9'd2;
        else if (fc == FC_RD_COILS || fc == FC_RD_DISCRETE)
            total = 9'd2 + bytes_q[8:0];
        else if (fc == FC_RD_HOLDING || fc == FC_RD_INPUT)
            total = 9'd2 + {q_w[7:0], 1'b0};
        else
            total = 9'd5;
    end

    always_comb
    begin
        st_next     = st_reg;
        hdr_next    = hdr_reg;
        k_next      = k_reg;
        len_next    = len_reg;
        unit_next   = unit_reg;
        exc_next    = exc_reg;
        off_next    = off_reg;
        i_next      = i_reg;
        acc_next    = acc_reg;
        hi_next     = hi_reg;
        e_next      = e_reg;
        pre_n_next  = pre_n_reg;
        pre_to_next = pre_to_reg;
        clr_next    = clr_reg;
        q_pop       = 1'b0;
        exec_done   = 1'b0;
        buf_a       = '0;
        emit        = '0;
        emit.total  = total;
        emit.exc    = exc_reg != EXC_NONE;
        coil_we = 1'b0; disc_we = 1'b0; hold_we = 1'b0; inw_we = 1'b0;
        coil_wa = el_addr[CI-1:0];
        disc_wa = ld_idx[DI-1:0];
        hold_wa = el_addr[HI-1:0];
        inw_wa  = ld_idx[WI-1:0];
        coil_wd = 1'b0; disc_wd = 1'b0; hold_wd = '0; inw_wd = '0;
        coil_re = 1'b0; disc_re = 1'b0; hold_re = 1'b0; inw_re = 1'b0;

        case (st_reg)
            ST_CLEAR:
            begin
                coil_we = clr_reg < COIL_D17;
                disc_we = clr_reg < DISC_D17;
                hold_we = clr_reg < HOLD_D17;
                inw_we  = clr_reg < INW_D17;
                coil_wa = clr_reg[CI-1:0];
                disc_wa = clr_reg[DI-1:0];
                hold_wa = clr_reg[HI-1:0];
                inw_wa  = clr_reg[WI-1:0];
                clr_next = clr_reg + 17'd1;
                if (clr_reg == MAXD_17 - 17'd1)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop   = 1'b1;
                    coil_wa = ld_idx[CI-1:0];
                    hold_wa = ld_idx[HI-1:0];
                    coil_wd = cmd.load_value[0];
                    disc_wd = cmd.load_value[0];
                    hold_wd = cmd.load_value;
                    inw_wd  = cmd.load_value;
                    case (cmd.kind)
                        REQ_LOAD_DISC: disc_we = ld_idx < DISC_D17;
                        REQ_LOAD_INW:  inw_we  = ld_idx < INW_D17;
                        REQ_LOAD_COIL: coil_we = ld_idx < COIL_D17;
                        REQ_LOAD_HOLD: hold_we = ld_idx < HOLD_D17;
                        default:
                        begin
                            len_next  = cmd.len;
                            unit_next = cmd.unit;
                            k_next    = '0;
                            st_next   = ST_HDR;
                        end
                    endcase
                end
            end
            ST_HDR:
            begin
                buf_a  = {9'b0, k_reg};
                k_next = k_reg + 3'd1;
                if (k_reg != 3'd0)
                begin
                    hdr_next = {hdr_reg[39:0], buf_rdata};
                end
                if (k_reg == 3'd6)
                begin
                    st_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                off_next = a_w - base_sel;
                if (!known)
                    exc_next = EXC_FUNCTION;
                else if (bad3)
                    exc_next = EXC_VALUE;
                else if (unit_reg != cfg.unit_address || !fits)
                    exc_next = EXC_ADDRESS;
                else
                    exc_next = EXC_NONE;
                st_next = ST_START;
            end
            ST_START:
            begin
                emit.start  = 1'b1;
                i_next      = '0;
                acc_next    = '0;
                e_next      = '0;
                pre_n_next  = 3'd2;
                pre_to_next = ST_DONE;
                st_next     = ST_PRE;
                if (exc_reg == EXC_NONE)
                begin
                    case (fc)
                        FC_RD_COILS, FC_RD_DISCRETE: pre_to_next = ST_BIT_REQ;
                        FC_RD_HOLDING, FC_RD_INPUT:  pre_to_next = ST_WORD_REQ;
                        FC_WR_COIL:                  st_next = ST_WR5;
                        FC_WR_REG:                   st_next = ST_WR6;
                        FC_WR_COILS:                 st_next = ST_WC_REQ;
                        default:                     st_next = ST_WH_A;
                    endcase
                end
            end
            ST_PRE:
            begin
                if (can_emit)
                begin
                    emit.valid = 1'b1;
                    emit.data  = pre_byte;
                    e_next     = e_reg + 3'd1;
                    if (e_reg == pre_n_reg - 3'd1)
                    begin
                        e_next  = '0;
                        st_next = pre_to_reg;
                    end
                end
            end
            ST_BIT_REQ:
            begin
                coil_re = fc == FC_RD_COILS;
                disc_re = fc != FC_RD_COILS;
                coil_wa = el_addr[CI-1:0];
                disc_wa = el_addr[DI-1:0];
                st_next = ST_BIT_GET;
            end
            ST_BIT_GET:
            begin
                acc_next = acc_reg | ({7'b0, rd_bit} << i_reg[2:0]);
                if (i_reg[2:0] == 3'd7 || i_end)
                begin
                    st_next = ST_BIT_EMIT;
                end
                else
                begin
                    i_next  = i_reg + 11'd1;
                    st_next = ST_BIT_REQ;
                end
            end
            ST_BIT_EMIT:
            begin
                if (can_emit)
                begin
                    emit.valid = 1'b1;
                    emit.data  = acc_reg;
                    acc_next   = '0;
                    i_next     = i_reg + 11'd1;
                    st_next    = i_end ? ST_DONE : ST_BIT_REQ;
                end
            end
            ST_WORD_REQ:
            begin
                hold_re = fc == FC_RD_HOLDING;
                inw_re  = fc != FC_RD_HOLDING;
                hold_wa = el_addr[HI-1:0];
                inw_wa  = el_addr[WI-1:0];
                st_next = ST_WORD_HI;
            end
            ST_WORD_HI:
            begin
                if (can_emit)
                begin
                    emit.valid = 1'b1;
                    emit.data  = rd_word[15:8];
                    st_next    = ST_WORD_LO;
                end
            end
            ST_WORD_LO:
            begin
                if (can_emit)
                begin
                    emit.valid = 1'b1;
                    emit.data  = rd_word[7:0];
                    i_next     = i_reg + 11'd1;
                    st_next    = i_end ? ST_DONE : ST_WORD_REQ;
                end
            end
            ST_WR5, ST_WR6:
            begin
                coil_we     = st_reg == ST_WR5;
                hold_we     = st_reg == ST_WR6;
                coil_wd     = q_w == COIL_ON;
                hold_wd     = q_w;
                pre_n_next  = 3'd5;
                pre_to_next = ST_DONE;
                st_next     = ST_PRE;
            end
            ST_WC_REQ:
            begin
                buf_a   = 12'd6 + {4'b0, i_reg[10:3]};
                st_next = ST_WC_GET;
            end
            ST_WC_GET:
            begin
                acc_next = buf_rdata;
                st_next  = ST_WC_BIT;
            end
            ST_WC_BIT:
            begin
                coil_we = 1'b1;
                coil_wd = acc_reg[i_reg[2:0]];
                i_next  = i_reg + 11'd1;
                if (i_end)
                begin
                    pre_n_next  = 3'd5;
                    pre_to_next = ST_DONE;
                    st_next     = ST_PRE;
                end
                else if (i_reg[2:0] == 3'd7)
                begin
                    st_next = ST_WC_REQ;
                end
            end
            ST_WH_A:
            begin
                buf_a   = 12'd6 + {i_reg, 1'b0};
                st_next = ST_WH_B;
            end
            ST_WH_B:
            begin
                buf_a   = 12'd7 + {i_reg, 1'b0};
                hi_next = buf_rdata;
                st_next = ST_WH_C;
            end
            ST_WH_C:
            begin
                hold_we = 1'b1;
                hold_wd = {hi_reg, buf_rdata};
                i_next  = i_reg + 11'd1;
                if (i_end)
                begin
                    pre_n_next  = 3'd5;
                    pre_to_next = ST_DONE;
                    st_next     = ST_PRE;
                end
                else
                begin
                    st_next = ST_WH_A;
                end
            end
            ST_DONE:
            begin
                exec_done = 1'b1;
                st_next   = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign buf_raddr = buf_a[BW-1:0];

    always_ff @(posedge clk)
    begin
        if (coil_we)
            coil_mem[coil_wa] <= coil_wd;
        if (coil_re)
            coil_rd_reg <= coil_mem[coil_wa];
        if (disc_we)
            disc_mem[disc_wa] <= disc_wd;
        if (disc_re)
            disc_rd_reg <= disc_mem[disc_wa];
        if (hold_we)
            hold_mem[hold_wa] <= hold_wd;
        if (hold_re)
            hold_rd_reg <= hold_mem[hold_wa];
        if (inw_we)
            inw_mem[inw_wa] <= inw_wd;
        if (inw_re)
            inw_rd_reg <= inw_mem[inw_wa];
    end

    always_ff @(posedge clk)
    begin
        hdr_reg    <= hdr_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        unit_reg   <= unit_next;
        exc_reg    <= exc_next;
        off_reg    <= off_next;
        i_reg      <= i_next;
        acc_reg    <= acc_next;
        hi_reg     <= hi_next;
        e_reg      <= e_next;
        pre_n_reg  <= pre_n_next;
        pre_to_reg <= pre_to_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_CLEAR;
            clr_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
        end
    end

endmodule

// ----- rtl/core/modbus_pdu_slave_engine.sv -----
// Modbus slave engine for function codes 1-6, 15 and 16. Request PDU bytes
// stream in one transaction each (tuser = 0, tlast on the final byte, which
// carries the unit id and starts execution); tuser 1..4 preload a discrete
// input, input register, coil or holding register. Responses leave as
// chunks of up to 8 bytes, first byte in bits 63..56, with tuser flagging
// exception responses. After reset the stores are cleared in one pass over
// the addresses of the deepest store with s_tready low; configuration writes
// are taken throughout. Loads and request bytes are accepted one per cycle
// while the command queue has room. A complete request is then run by the
// back-end sequencer: header fetch and checks, then coil or discrete bit
// reads, register reads, coil writes with a fetch per data byte, or register
// writes, and the response bytes one at a time, all serialized by the
// single-ported stores and the request buffer's read port. New request bytes
// wait while a request executes; load items keep queueing behind it.
module modbus_pdu_slave_engine
    import mbslv_pkg::*;
#(
    parameter int COIL_DEPTH       = 1024,
    parameter int DISCRETE_DEPTH   = 1024,
    parameter int HOLDING_DEPTH    = 256,
    parameter int INPUT_WORD_DEPTH = 256,
    parameter int PDU_BYTES        = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // tdata: pdu_byte[7:0], request_unit[15:8], load_index[25:16],
    //        load_value[41:26], zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [2:0]  s_tuser,   // req_type
    input  logic        s_tlast,   // pdu_end
    // tdata: resp_chunk[63:0], chunk_bytes[67:64], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic        m_tuser,   // is_exception
    output logic        m_tlast,   // resp_last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    localparam int BW = $clog2(PDU_BYTES);

    cfg_t          cfg_reg;
    cmd_t          push_cmd;
    cmd_t          head_cmd;
    emit_t         emit;
    logic          q_push, q_pop, q_empty, q_full;
    logic          clear_busy, exec_done, can_emit;
    logic [BW-1:0] buf_raddr;
    logic [7:0]    buf_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_address    <= 8'd1;
            cfg_reg.coil_base       <= '0;
            cfg_reg.discrete_base   <= '0;
            cfg_reg.holding_base    <= '0;
            cfg_reg.input_word_base <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UNIT:     cfg_reg.unit_address    <= cfg_wdata[7:0];
                CFG_COIL:     cfg_reg.coil_base       <= cfg_wdata;
                CFG_DISCRETE: cfg_reg.discrete_base   <= cfg_wdata;
                CFG_HOLDING:  cfg_reg.holding_base    <= cfg_wdata;
                CFG_INPUT:    cfg_reg.input_word_base <= cfg_wdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end: byte collection and item classification
    mbslv_front #(
        .PDU_BYTES (PDU_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .clear_busy (clear_busy),
        .exec_done  (exec_done),
        .buf_raddr  (buf_raddr),
        .buf_rdata  (buf_rdata)
    );

    mbslv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back end: store access and response sequencing
    mbslv_back #(
        .COIL_DEPTH       (COIL_DEPTH),
        .DISCRETE_DEPTH   (DISCRETE_DEPTH),
        .HOLDING_DEPTH    (HOLDING_DEPTH),
        .INPUT_WORD_DEPTH (INPUT_WORD_DEPTH),
        .PDU_BYTES        (PDU_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (head_cmd),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .buf_raddr  (buf_raddr),
        .buf_rdata  (buf_rdata),
        .emit       (emit),
        .can_emit   (can_emit),
        .exec_done  (exec_done),
        .clear_busy (clear_busy)
    );

    // response bytes packed into chunks behind an output register
    mbslv_packer u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .can_emit (can_emit),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
